// File: rtl/core/nlas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nlas_pkg
// Shared types and constants of the nearest landmark ahead search.
// ----------------------------------------------------------------------------
package nlas_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = ADDR_W + 1;
   localparam int POS_W         = 40;
   localparam int HD_W          = 16;
   localparam int DIST_W        = 20;
   localparam int WIN_W         = 15;
   localparam int LIM_W         = 2 * DIST_W;
   localparam int TRIG_W        = 18;
   localparam int SINE_CYCLES   = 4;
   localparam int SQRT_STEPS    = DIST_W;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIST = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT    = 2'd2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // quarter-wave sine polynomial coefficients
   localparam logic [16:0] SINE_T0 = 17'd84095;
   localparam logic [17:0] SINE_U0 = 18'd205887;
   localparam logic [13:0] SINE_K  = 14'd9279;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SINE,
      ST_SCAN,
      ST_DRAIN,
      ST_SQRT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              load_pose;
      logic              write_entry;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              sqrt_init;
      logic              sqrt_step;
      logic [4:0]        sqrt_k;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic             pipe_busy;
      logic [CNT_W-1:0] scan_count;
   } status_type;

endpackage
`default_nettype wire

// File: rtl/core/nearest_landmark_ahead_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_landmark_ahead_search
// Landmark table with nearest-ahead query and integer distance result.
// ----------------------------------------------------------------------------
// channel | dir | tuser        | tdata (low bit first)
// req     | in  | op           | slot[5:0] pos_x[45:6] pos_y[85:46] heading[101:86]
// rsp     | out | found        | nearest_index[5:0] nearest_distance_mm[25:6]
// csr     | in  | -            | csr_index = register, csr_data = value
//
// A load request is taken in the idle state and writes the table entry at once.
// A query for N searched entries (N up to 64) runs these phases in order:
// sine warm-up, one table read a cycle, pipeline drain, 20 square root steps.
// A waiting result does not block load requests; a further query is taken
// and run, but its result sits in the done state, holding off all requests,
// until its predecessor's result has left the output register.
// Synchronous active-high reset; the table itself is not cleared.
// ----------------------------------------------------------------------------
module nearest_landmark_ahead_search import nlas_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [103:0]          req_tdata,   // slot, pos_x, pos_y, heading, pad
   input  wire logic [0:0]            req_tuser,   // op
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [31:0]                rsp_tdata,   // nearest_index, nearest_distance_mm, pad
   output logic [0:0]                 rsp_tuser,   // found
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type           cmd;
   status_type        status;
   logic              found;
   logic [ADDR_W-1:0] nearest_index;
   logic [DIST_W-1:0] nearest_distance_mm;

   // registers are always writable
   assign csr_ready = 1'b1;

   nlas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser[0]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   nlas_dpath u_dpath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .csr_we                  (csr_valid),
      .csr_index               (csr_index),
      .csr_data                (csr_data),
      .req_slot                (req_tdata[5:0]),
      .req_pos_x               (req_tdata[45:6]),
      .req_pos_y               (req_tdata[85:46]),
      .req_heading             (req_tdata[101:86]),
      .rsp_found               (found),
      .rsp_nearest_index       (nearest_index),
      .rsp_nearest_distance_mm (nearest_distance_mm)
   );

   assign rsp_tuser = found;
   assign rsp_tdata = {6'b0, nearest_distance_mm, nearest_index};

endmodule
`default_nettype wire

// File: rtl/core/nlas_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nlas_ctrl
// Sequencer: sine warm-up, table scan, drain, square root, result hand-off.
// ----------------------------------------------------------------------------
module nlas_ctrl import nlas_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_op,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // next state and counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept && req_op == OP_QUERY) begin
               state_in = ST_SINE;
            end
         end
         ST_SINE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SINE_CYCLES - 1)) begin
               cnt_in   = '0;
               state_in = (status.scan_count == '0) ? ST_DRAIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == status.scan_count - 1'b1) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cnt_in = '0;
            if (!status.pipe_busy) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd             = '0;
      cmd.load_pose   = (state_ff == ST_IDLE) && accept && req_op == OP_QUERY;
      cmd.write_entry = (state_ff == ST_IDLE) && accept && req_op == OP_LOAD;
      cmd.rd_en       = (state_ff == ST_SCAN);
      cmd.rd_addr     = cnt_ff[ADDR_W-1:0];
      cmd.sqrt_init   = (state_ff == ST_DRAIN) && !status.pipe_busy;
      cmd.sqrt_step   = (state_ff == ST_SQRT);
      cmd.sqrt_k      = cnt_ff[4:0];
      cmd.out_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/nlas_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nlas_dpath
// Landmark table, sine lanes, scan pipeline, best tracker, bitwise square root.
// ----------------------------------------------------------------------------
module nlas_dpath import nlas_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic [ADDR_W-1:0]     req_slot,
   input  wire logic [POS_W-1:0]      req_pos_x,
   input  wire logic [POS_W-1:0]      req_pos_y,
   input  wire logic [HD_W-1:0]       req_heading,
   output logic                       rsp_found,
   output logic [ADDR_W-1:0]          rsp_nearest_index,
   output logic [DIST_W-1:0]          rsp_nearest_distance_mm
);

   // configuration
   logic [DIST_W-1:0] max_dist_ff;
   logic [WIN_W-1:0]  window_ff;
   logic [6:0]        count_ff;
   logic [LIM_W-1:0]  lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff <= DIST_W'(110000);
         window_ff   <= WIN_W'(1820);
         count_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_DIST: max_dist_ff <= csr_data[DIST_W-1:0];
            CSR_WINDOW:   window_ff   <= csr_data[WIN_W-1:0];
            CSR_COUNT:    count_ff    <= csr_data[6:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      lim_ff <= max_dist_ff * max_dist_ff;
   end

   assign status.scan_count = (count_ff > 7'(TABLE_ENTRIES)) ?
                              CNT_W'(TABLE_ENTRIES) : CNT_W'(count_ff);

   // landmark table
   logic [POS_W-1:0] mem_x [TABLE_ENTRIES];
   logic [POS_W-1:0] mem_y [TABLE_ENTRIES];
   logic [HD_W-1:0]  mem_h [TABLE_ENTRIES];
   logic [POS_W-1:0] rd_x_ff, rd_y_ff;
   logic [HD_W-1:0]  rd_h_ff;

   always_ff @(posedge clock) begin
      if (cmd.write_entry && ({1'b0, req_slot} < CNT_W'(TABLE_ENTRIES))) begin
         mem_x[req_slot] <= req_pos_x;
         mem_y[req_slot] <= req_pos_y;
         mem_h[req_slot] <= req_heading;
      end
      if (cmd.rd_en) begin
         rd_x_ff <= mem_x[cmd.rd_addr];
         rd_y_ff <= mem_y[cmd.rd_addr];
         rd_h_ff <= mem_h[cmd.rd_addr];
      end
   end

   // vehicle pose
   logic [POS_W-1:0] vx_ff, vy_ff;
   logic [HD_W-1:0]  vh_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_pose) begin
         vx_ff <= req_pos_x;
         vy_ff <= req_pos_y;
         vh_ff <= req_heading;
      end
   end

   // sine lanes: 0 is cosine, 1 is sine; one multiply per stage
   logic [HD_W-1:0]          ang   [2];
   logic [14:0]              off   [2];
   logic [16:0]              z0    [2];
   logic [16:0]              z1_ff [2], z2a_ff [2], z3_ff [2];
   logic [16:0]              sq1_ff [2], sq2_ff [2];
   logic [16:0]              t_ff  [2];
   logic [17:0]              u_ff  [2];
   logic                     n1_ff [2], n2_ff [2], n3_ff [2];
   logic signed [TRIG_W-1:0] trig_ff [2];
   logic [33:0]              p_zz  [2];
   logic [30:0]              p_k   [2];
   logic [33:0]              p_t   [2];
   logic [34:0]              p_u   [2];

   assign ang[0] = vh_ff + 16'd16384;
   assign ang[1] = vh_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         off[l]  = ang[l][14] ? 15'(15'd16384 - {1'b0, ang[l][13:0]})
                              : {1'b0, ang[l][13:0]};
         z0[l]   = {off[l], 2'b00};
         p_zz[l] = z0[l] * z0[l];
         p_k[l]  = sq1_ff[l] * SINE_K;
         p_t[l]  = sq2_ff[l] * t_ff[l];
         p_u[l]  = z3_ff[l] * u_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         z1_ff[l]   <= z0[l];
         sq1_ff[l]  <= p_zz[l][32:16];
         n1_ff[l]   <= ang[l][15];
         z2a_ff[l]  <= z1_ff[l];
         sq2_ff[l]  <= sq1_ff[l];
         t_ff[l]    <= SINE_T0 - {2'b00, p_k[l][30:16]};
         n2_ff[l]   <= n1_ff[l];
         z3_ff[l]   <= z2a_ff[l];
         u_ff[l]    <= SINE_U0 - p_t[l][33:16];
         n3_ff[l]   <= n2_ff[l];
         trig_ff[l] <= n3_ff[l] ? -$signed({1'b0, p_u[l][33:17]})
                                : $signed({1'b0, p_u[l][33:17]});
      end
   end

   // scan pipeline
   logic              v1_ff, v2_ff, v3_ff;
   logic [ADDR_W-1:0] i1_ff, i2_ff, i3_ff;
   logic signed [POS_W:0] dx, dy;
   logic [POS_W:0]    adx, ady;
   logic [HD_W-1:0]   hdiff;
   logic [HD_W:0]     adiff;
   logic [DIST_W-1:0] adx_ff, ady_ff;
   logic signed [DIST_W:0] dx_ff, dy_ff;
   logic              far2_ff, hok2_ff, far3_ff, hok3_ff;
   logic [LIM_W-1:0]  sqx_ff, sqy_ff;
   logic signed [DIST_W+TRIG_W:0] dotx_ff, doty_ff;

   assign status.pipe_busy = v1_ff || v2_ff || v3_ff;

   always_comb begin
      dx    = $signed({rd_x_ff[POS_W-1], rd_x_ff}) - $signed({vx_ff[POS_W-1], vx_ff});
      dy    = $signed({rd_y_ff[POS_W-1], rd_y_ff}) - $signed({vy_ff[POS_W-1], vy_ff});
      adx   = dx[POS_W] ? (POS_W+1)'(-dx) : dx;
      ady   = dy[POS_W] ? (POS_W+1)'(-dy) : dy;
      hdiff = vh_ff - rd_h_ff;
      adiff = hdiff[HD_W-1] ? 17'(17'd65536 - {1'b0, hdiff}) : {1'b0, hdiff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.rd_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      i1_ff   <= cmd.rd_addr;
      i2_ff   <= i1_ff;
      i3_ff   <= i2_ff;
      // anything past 2^20 mm on one axis is beyond every distance limit
      far2_ff <= (|adx[POS_W:DIST_W]) || (|ady[POS_W:DIST_W]);
      hok2_ff <= adiff < {2'b00, window_ff};
      adx_ff  <= adx[DIST_W-1:0];
      ady_ff  <= ady[DIST_W-1:0];
      dx_ff   <= dx[DIST_W:0];
      dy_ff   <= dy[DIST_W:0];
      far3_ff <= far2_ff;
      hok3_ff <= hok2_ff;
      sqx_ff  <= adx_ff * adx_ff;
      sqy_ff  <= ady_ff * ady_ff;
      dotx_ff <= dx_ff * trig_ff[0];
      doty_ff <= dy_ff * trig_ff[1];
   end

   // best tracker
   logic [LIM_W:0]            sq;
   logic signed [DIST_W+TRIG_W+1:0] dot;
   logic                      qual;
   logic                      found_ff;
   logic [LIM_W-1:0]          best_sq_ff;
   logic [ADDR_W-1:0]         best_idx_ff;

   always_comb begin
      sq   = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      dot  = {dotx_ff[DIST_W+TRIG_W], dotx_ff} + {doty_ff[DIST_W+TRIG_W], doty_ff};
      qual = v3_ff && !far3_ff && hok3_ff && (sq <= {1'b0, lim_ff}) &&
             (!found_ff || sq < {1'b0, best_sq_ff}) && !dot[DIST_W+TRIG_W+1];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load_pose) begin
         found_ff    <= 1'b0;
         best_sq_ff  <= '0;
         best_idx_ff <= '0;
      end else if (qual) begin
         found_ff    <= 1'b1;
         best_sq_ff  <= sq[LIM_W-1:0];
         best_idx_ff <= i3_ff;
      end
   end

   // square root, one result bit per step
   logic [LIM_W-1:0] rem_ff, res_ff;
   logic [LIM_W-1:0] sbit;
   logic [LIM_W:0]   trial;

   always_comb begin
      sbit  = LIM_W'(1) << (6'(LIM_W - 2) - {cmd.sqrt_k, 1'b0});
      trial = {1'b0, res_ff} + {1'b0, sbit};
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         rem_ff <= best_sq_ff;
         res_ff <= '0;
      end else if (cmd.sqrt_step) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_ff <= rem_ff - trial[LIM_W-1:0];
            res_ff <= (res_ff >> 1) + sbit;
         end else begin
            res_ff <= res_ff >> 1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_found               <= found_ff;
         rsp_nearest_index       <= found_ff ? best_idx_ff : '0;
         rsp_nearest_distance_mm <= found_ff ? res_ff[DIST_W-1:0] : '0;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/nlas_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nlas_checker
// Port-level checks of the nearest landmark ahead search.
// ----------------------------------------------------------------------------
module nlas_checker import nlas_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [0:0]            req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [31:0]           rsp_tdata,
   input wire logic [0:0]            rsp_tuser
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 32'd0)
      else $error("empty result carries data");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] == OP_LOAD && !rsp_tvalid |=> !rsp_tvalid)
      else $error("load request produced a result");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] == OP_QUERY |=> !req_tready)
      else $error("request taken during a query");

endmodule

bind nearest_landmark_ahead_search nlas_checker u_nlas_checker (.*);
`default_nettype wire
